// ===== hw/rtl/slx_pkg.sv =====
`default_nettype none
package slx_pkg;

  // Width of the internal line and column counters; reported in 16 bits.
  localparam int POS_BITS   = 16;
  localparam int FIELD_BITS = 16;

  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [4:0]            kind_t;

  localparam pos_t   POS_MAX = '1;
  localparam pos_t   POS_ONE = POS_BITS'(1);
  localparam field_t LEN_MAX = '1;

  // Token kinds
  localparam kind_t K_LPAREN   = 5'd0;
  localparam kind_t K_RPAREN   = 5'd1;
  localparam kind_t K_LBRACK   = 5'd2;
  localparam kind_t K_RBRACK   = 5'd3;
  localparam kind_t K_SEMI     = 5'd4;
  localparam kind_t K_COMMA    = 5'd5;
  localparam kind_t K_LBRACE   = 5'd6;
  localparam kind_t K_RBRACE   = 5'd7;
  localparam kind_t K_PERCENT  = 5'd8;
  localparam kind_t K_AMP      = 5'd9;
  localparam kind_t K_PLUS_EQ  = 5'd10;
  localparam kind_t K_INCR     = 5'd11;
  localparam kind_t K_PLUS     = 5'd12;
  localparam kind_t K_MINUS_EQ = 5'd13;
  localparam kind_t K_DECR     = 5'd14;
  localparam kind_t K_MINUS    = 5'd15;
  localparam kind_t K_STAR_EQ  = 5'd16;
  localparam kind_t K_STAR     = 5'd17;
  localparam kind_t K_LE       = 5'd18;
  localparam kind_t K_LT       = 5'd19;
  localparam kind_t K_GE       = 5'd20;
  localparam kind_t K_GT       = 5'd21;
  localparam kind_t K_EQ_EQ    = 5'd22;
  localparam kind_t K_ASSIGN   = 5'd23;
  localparam kind_t K_NOT_EQ   = 5'd24;
  localparam kind_t K_NOT      = 5'd25;
  localparam kind_t K_SLASH_EQ = 5'd26;
  localparam kind_t K_SLASH    = 5'd27;
  localparam kind_t K_IDENT    = 5'd28;
  localparam kind_t K_INT      = 5'd29;
  localparam kind_t K_REAL     = 5'd30;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_LINE,
    MODE_BLOCK,
    MODE_BLOCK_STAR
  } mode_t;

  typedef enum logic [3:0] {
    PEND_NONE,
    PEND_PLUS,
    PEND_MINUS,
    PEND_STAR,
    PEND_LT,
    PEND_GT,
    PEND_EQ,
    PEND_BANG,
    PEND_SLASH
  } pend_t;

  typedef enum logic [2:0] {
    CLS_START,
    CLS_INT,
    CLS_REAL,
    CLS_EXP_NEED,
    CLS_EXP,
    CLS_FSUF,
    CLS_ID
  } cls_t;

  typedef struct packed {
    kind_t  kind;
    field_t line;
    field_t col;
    field_t len;
    logic   last;
  } tok_t;

  // Up to two tokens produced by one step, first one in slot first.
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } emit_t;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  function automatic field_t pos_field(pos_t p);
    logic [31:0] w;
    w = 32'(p);
    return w[FIELD_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/slx_core.sv =====
`default_nettype none
module slx_core
  import slx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_text,
  output emit_t           emit
);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  mode_t  mode, mode_next;
  pend_t  pend, pend_next;
  cls_t   cls, cls_next;
  field_t word_len, word_len_next;
  pos_t   line, line_next;
  pos_t   col, col_next;
  pos_t   start, start_next;

  logic  is_blank, sk_valid, pend_hit, consumed, word_held;
  kind_t sk_kind, word_kind;
  pend_t oc;

  function automatic cls_t class_next(cls_t c_in, logic [7:0] c);
    logic digit, is_e, is_f, dot;
    cls_t r;
    digit = (c >= "0") && (c <= "9");
    is_e  = c inside {"e", "E"};
    is_f  = c inside {"f", "F"};
    dot   = (c == ".");
    r     = CLS_ID;
    case (c_in)
      CLS_START: begin
        if (is_e || is_f) r = CLS_ID;
        else if (digit) r = CLS_INT;
        else if (dot) r = CLS_REAL;
      end
      CLS_INT: begin
        if (digit) r = CLS_INT;
        else if (dot) r = CLS_REAL;
        else if (is_e) r = CLS_EXP_NEED;
      end
      CLS_REAL: begin
        if (digit) r = CLS_REAL;
        else if (is_e) r = CLS_EXP_NEED;
        else if (is_f) r = CLS_FSUF;
      end
      CLS_EXP_NEED, CLS_EXP: begin
        if (digit) r = CLS_EXP;
        else if (is_f) r = CLS_FSUF;
      end
      default: r = CLS_ID;
    endcase
    return r;
  endfunction

  function automatic kind_t single_of(pend_t p);
    case (p)
      PEND_PLUS:  return K_PLUS;
      PEND_MINUS: return K_MINUS;
      PEND_STAR:  return K_STAR;
      PEND_LT:    return K_LT;
      PEND_GT:    return K_GT;
      PEND_EQ:    return K_ASSIGN;
      PEND_BANG:  return K_NOT;
      default:    return K_SLASH;
    endcase
  endfunction

  function automatic kind_t eq_of(pend_t p);
    case (p)
      PEND_PLUS:  return K_PLUS_EQ;
      PEND_MINUS: return K_MINUS_EQ;
      PEND_STAR:  return K_STAR_EQ;
      PEND_LT:    return K_LE;
      PEND_GT:    return K_GE;
      PEND_EQ:    return K_EQ_EQ;
      PEND_BANG:  return K_NOT_EQ;
      default:    return K_SLASH_EQ;
    endcase
  endfunction

  // Character decode
  always_comb begin
    is_blank = char_code inside {CH_SPACE, CH_LF, CH_TAB, CH_CR};
    sk_valid = 1'b1;
    case (char_code)
      "(":     sk_kind = K_LPAREN;
      ")":     sk_kind = K_RPAREN;
      "[":     sk_kind = K_LBRACK;
      "]":     sk_kind = K_RBRACK;
      ";":     sk_kind = K_SEMI;
      ",":     sk_kind = K_COMMA;
      "{":     sk_kind = K_LBRACE;
      "}":     sk_kind = K_RBRACE;
      "%":     sk_kind = K_PERCENT;
      "&":     sk_kind = K_AMP;
      default: begin
        sk_kind  = K_LPAREN;
        sk_valid = 1'b0;
      end
    endcase
    case (char_code)
      "+":     oc = PEND_PLUS;
      "-":     oc = PEND_MINUS;
      "*":     oc = PEND_STAR;
      "<":     oc = PEND_LT;
      ">":     oc = PEND_GT;
      "=":     oc = PEND_EQ;
      "!":     oc = PEND_BANG;
      "/":     oc = PEND_SLASH;
      default: oc = PEND_NONE;
    endcase
    pend_hit = (char_code == "=")
             || (pend == PEND_PLUS && char_code == "+")
             || (pend == PEND_MINUS && char_code == "-")
             || (pend == PEND_SLASH && (char_code == "/" || char_code == "*"));
    consumed  = (pend != PEND_NONE) && pend_hit;
    word_held = (cls != CLS_START);
    case (cls)
      CLS_INT:                     word_kind = K_INT;
      CLS_REAL, CLS_EXP, CLS_FSUF: word_kind = K_REAL;
      default:                     word_kind = K_IDENT;
    endcase
  end

  // Next state
  always_comb begin
    mode_next     = mode;
    pend_next     = pend;
    cls_next      = cls;
    word_len_next = word_len;
    line_next     = line;
    col_next      = col;
    start_next    = start;
    if (end_of_text) begin
      mode_next     = MODE_NORMAL;
      pend_next     = PEND_NONE;
      cls_next      = CLS_START;
      word_len_next = '0;
      line_next     = POS_ONE;
      col_next      = POS_ONE;
      start_next    = '0;
    end else begin
      case (mode)
        MODE_LINE: begin
          if (char_code == CH_LF) mode_next = MODE_NORMAL;
        end
        MODE_BLOCK: begin
          if (char_code == "*") mode_next = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (char_code == "/") mode_next = MODE_NORMAL;
          else if (char_code != "*") mode_next = MODE_BLOCK;
        end
        default: begin
          pend_next = PEND_NONE;
          if (consumed && char_code == "/") mode_next = MODE_LINE;
          if (consumed && char_code == "*") mode_next = MODE_BLOCK;
          if (!consumed) begin
            if (is_blank || sk_valid || oc != PEND_NONE) begin
              word_len_next = '0;
              cls_next      = CLS_START;
              if (oc != PEND_NONE) begin
                pend_next  = oc;
                start_next = col;
              end
            end else begin
              if (word_len == '0) start_next = col;
              if (word_len != LEN_MAX) word_len_next = word_len + 1'b1;
              cls_next = class_next(cls, char_code);
            end
          end
        end
      endcase
      if (char_code == CH_LF) begin
        if (line != POS_MAX) line_next = line + 1'b1;
        col_next = POS_ONE;
      end else if (col != POS_MAX) begin
        col_next = col + 1'b1;
      end
    end
  end

  // Token outputs
  always_comb begin
    logic opv, wv, sv;
    tok_t op_tok, word_tok, sk_tok;
    opv = 1'b0;
    wv  = 1'b0;
    sv  = 1'b0;
    op_tok.kind   = single_of(pend);
    op_tok.line   = pos_field(line);
    op_tok.col    = pos_field(start);
    op_tok.len    = FIELD_BITS'(1);
    op_tok.last   = 1'b0;
    word_tok.kind = word_kind;
    word_tok.line = pos_field(line);
    word_tok.col  = pos_field(start);
    word_tok.len  = word_len;
    word_tok.last = 1'b0;
    sk_tok.kind   = sk_kind;
    sk_tok.line   = pos_field(line);
    sk_tok.col    = pos_field(col);
    sk_tok.len    = FIELD_BITS'(1);
    sk_tok.last   = 1'b1;
    if (mode == MODE_NORMAL) begin
      if (end_of_text) begin
        opv = (pend != PEND_NONE);
        wv  = (pend == PEND_NONE) && word_held;
      end else begin
        if (pend != PEND_NONE) begin
          opv = !(consumed && (char_code == "/" || char_code == "*"));
          if (char_code == "=") begin
            op_tok.kind = eq_of(pend);
            op_tok.len  = FIELD_BITS'(2);
          end else if (pend == PEND_PLUS && char_code == "+") begin
            op_tok.kind = K_INCR;
            op_tok.len  = FIELD_BITS'(2);
          end else if (pend == PEND_MINUS && char_code == "-") begin
            op_tok.kind = K_DECR;
            op_tok.len  = FIELD_BITS'(2);
          end
        end
        if (!consumed) begin
          wv = word_held && (is_blank || sk_valid || oc != PEND_NONE);
          sv = sk_valid;
        end
      end
    end
    emit.second = sk_tok;
    if (opv) emit.first = op_tok;
    else if (wv) emit.first = word_tok;
    else emit.first = sk_tok;
    if (opv || wv) begin
      emit.count      = sv ? 2'd2 : 2'd1;
      emit.first.last = !sv;
    end else begin
      emit.count = sv ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_NORMAL;
      pend     <= PEND_NONE;
      cls      <= CLS_START;
      word_len <= '0;
      line     <= POS_ONE;
      col      <= POS_ONE;
      start    <= '0;
    end else if (step) begin
      mode     <= mode_next;
      pend     <= pend_next;
      cls      <= cls_next;
      word_len <= word_len_next;
      line     <= line_next;
      col      <= col_next;
      start    <= start_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/slx_result_fifo.sv =====
`default_nettype none
module slx_result_fifo
  import slx_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire emit_t emit,
  input  wire logic  pop,
  output tok_t       head,
  output logic       head_valid,
  output logic       room
);

  tok_t                 mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic [FIFO_CW-1:0]   push_n;
  logic                 do_pop;

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  // Room for a worst-case step of two tokens
  assign room       = (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign push_n     = push ? FIFO_CW'(emit.count) : '0;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push && emit.count != 2'd0) mem[wr_ptr] <= emit.first;
    if (push && emit.count == 2'd2) mem[wr_ptr + 1'b1] <= emit.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_n);
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count  <= count + push_n - FIFO_CW'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/script_lexer_token_stream_unit.sv =====
// Channel  Dir  Handshake              Payload
// src      in   src_valid/src_stall    char_code, end_of_text
// tok      out  tok_valid/tok_stall    token_kind, line_number, start_column,
//                                      token_length, last_of_run
//
// One character item is taken per cycle while src_stall is low. An accepted
// item sits in the input register until the FIFO has room; at the edge that
// advances it, the lexer core updates its state and writes zero, one or two
// tokens into a four-entry result FIFO, whose head is shown on tok.
// The FIFO read port drains one token a cycle while tok_stall is low, so
// the two tokens of an item that produces two leave one after the other.
// Reset (rst, synchronous) returns the lexer to line 1, column 1 and empties
// the FIFO. src_stall rises when the input register is held because the FIFO
// has fewer than two free entries.
`default_nettype none
module script_lexer_token_stream_unit
  import slx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        src_valid,
  output logic             src_stall,
  input  wire logic [7:0]  char_code,
  input  wire logic        end_of_text,
  output logic             tok_valid,
  input  wire logic        tok_stall,
  output logic [4:0]       token_kind,
  output logic [15:0]      line_number,
  output logic [15:0]      start_column,
  output logic [15:0]      token_length,
  output logic             last_of_run
);

  // Input register
  logic       hold_full;
  logic [7:0] hold_char;
  logic       hold_eot;

  logic  room;
  logic  step;
  logic  src_take;
  emit_t emit;
  tok_t  head;

  // Advance the held item only when the FIFO can take a full step
  assign step      = hold_full && room;
  assign src_stall = hold_full && !room;
  assign src_take  = src_valid && !src_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_full <= 1'b0;
    end else if (src_take) begin
      hold_full <= 1'b1;
    end else if (step) begin
      hold_full <= 1'b0;
    end
  end

  // Payload: load on accept, no reset needed
  always_ff @(posedge clk) begin
    if (src_take) begin
      hold_char <= char_code;
      hold_eot  <= end_of_text;
    end
  end

  slx_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .char_code   (hold_char),
    .end_of_text (hold_eot),
    .emit        (emit)
  );

  slx_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .emit       (emit),
    .pop        (!tok_stall),
    .head       (head),
    .head_valid (tok_valid),
    .room       (room)
  );

  assign token_kind   = head.kind;
  assign line_number  = head.line;
  assign start_column = head.col;
  assign token_length = head.len;
  assign last_of_run  = head.last;

endmodule
`default_nettype wire

// ===== hw/rtl/slx_checker.sv =====
`default_nettype none
module slx_checker
  import slx_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        src_valid,
  input wire logic        src_stall,
  input wire logic [7:0]  char_code,
  input wire logic        end_of_text,
  input wire logic        tok_valid,
  input wire logic        tok_stall,
  input wire logic [4:0]  token_kind,
  input wire logic [15:0] line_number,
  input wire logic [15:0] start_column,
  input wire logic [15:0] token_length,
  input wire logic        last_of_run
);

  // Nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !tok_valid)
    else $error("token valid after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_stall |=> tok_valid && $stable(token_kind)
      && $stable(token_length) && $stable(last_of_run))
    else $error("stalled token changed");

  a_fields_sane: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> token_kind <= K_REAL && token_length != 16'd0
      && line_number != 16'd0)
    else $error("token field out of range");

  // Operators and punctuation are one or two characters long
  a_op_len: assert property (@(posedge clk) disable iff (rst)
    tok_valid && token_kind < K_IDENT |-> token_length == 16'd1
      || token_length == 16'd2)
    else $error("operator token of wrong length");

  // The input is never stalled while the output has no token to deliver
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> tok_valid)
    else $error("input stalled with nothing to deliver");

endmodule

bind script_lexer_token_stream_unit slx_checker u_slx_checker (.*);
`default_nettype wire
